>>> hdl/omni_wheel_speed_mixer_assert.svh
// Assertion macros shared by the omni wheel speed mixer modules.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef OMNI_WHEEL_SPEED_MIXER_ASSERT_SVH
`define OMNI_WHEEL_SPEED_MIXER_ASSERT_SVH

// Same-cycle implication.
`define OWSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OWSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/owsm_pkg.sv
// Package for the omni wheel speed mixer: widths, register indexes, reset values and
// the sideband struct carried through the divider. No dependencies.
package owsm_pkg;

  localparam int LANES   = 4;
  localparam int FRAC    = 38;
  localparam int DIVW    = 48;
  localparam int QW      = 15;
  localparam int NUMW    = DIVW + QW;
  localparam int SHW     = 5;

  localparam logic [2:0] REG_COEFF_TR = 3'd0;
  localparam logic [2:0] REG_COEFF_BR = 3'd1;
  localparam logic [2:0] REG_COEFF_BL = 3'd2;
  localparam logic [2:0] REG_COEFF_TL = 3'd3;
  localparam logic [2:0] REG_SCALE    = 3'd4;
  localparam logic [2:0] REG_MAX_RPM  = 3'd5;

  localparam logic [31:0] SCALE_RESET   = 32'd65536;
  localparam logic [14:0] MAX_RPM_RESET = 15'd16383;

  typedef struct packed {
    logic                        lim;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][QW-1:0]    raw;
  } owsm_side_t;

endpackage

>>> hdl/omni_wheel_speed_mixer.sv
// Omni wheel speed mixer top level: an accepted request passes through 6 mixing/peak
// stages, 15 divider stages and 1 output register to its result.
// Throughput one request per cycle; a stall only halts stages that hold data.
// The quotient width of the divider pipeline sets the depth.
// Synchronous reset clears all valid bits and loads register reset values.
`include "omni_wheel_speed_mixer_assert.svh"

module omni_wheel_speed_mixer
  import owsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] forward_speed,
  input  logic signed [15:0] left_speed,
  input  logic signed [15:0] turn_rate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] speed_top_right,
  output logic signed [15:0] speed_bottom_right,
  output logic signed [15:0] speed_bottom_left,
  output logic signed [15:0] speed_top_left
);

  // Configuration registers.
  logic [LANES-1:0][47:0] coeffs;
  logic [31:0]            scale;
  logic [14:0]            max_rpm;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeffs  <= '0;
      scale   <= SCALE_RESET;
      max_rpm <= MAX_RPM_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COEFF_TR: coeffs[0] <= cfg_data;
        REG_COEFF_BR: coeffs[1] <= cfg_data;
        REG_COEFF_BL: coeffs[2] <= cfg_data;
        REG_COEFF_TL: coeffs[3] <= cfg_data;
        REG_SCALE:    scale     <= cfg_data[31:0];
        REG_MAX_RPM:  max_rpm   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;
  logic d_in_stall, d_out_valid, d_out_stall, en_o;

  assign en_o        = !out_valid || !out_stall;
  assign d_out_stall = !en_o;
  assign en6 = !v6 || !d_in_stall;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  // Stage 1: the twelve products.
  logic signed [31:0] s1_pf [LANES];
  logic signed [31:0] s1_pl [LANES];
  logic signed [31:0] s1_pr [LANES];

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int l = 0; l < LANES; l++) begin
        s1_pf[l] <= forward_speed * $signed(coeffs[l][15:0]);
        s1_pl[l] <= left_speed    * $signed(coeffs[l][31:16]);
        s1_pr[l] <= turn_rate     * $signed(coeffs[l][47:32]);
      end
    end
  end

  // Stage 2: sum, sign and magnitude.
  logic [LANES-1:0][31:0] s2_a;
  logic [LANES-1:0]       s2_neg;
  logic signed [33:0]     sum [LANES];
  logic [33:0]            sum_abs [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sum[l]     = 34'(s1_pf[l]) + 34'(s1_pl[l]) + 34'(s1_pr[l]);
      sum_abs[l] = sum[l][33] ? 34'(-sum[l]) : 34'(sum[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int l = 0; l < LANES; l++) begin
        s2_a[l]   <= sum_abs[l][31:0];
        s2_neg[l] <= sum[l][33];
      end
    end
  end

  // Stage 3: scale to RPM with 38 fraction bits.
  logic [LANES-1:0][63:0] s3_m;
  logic [LANES-1:0]       s3_neg;

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int l = 0; l < LANES; l++) begin
        s3_m[l] <= 64'(s2_a[l]) * 64'(scale);
      end
      s3_neg <= s2_neg;
    end
  end

  // Stage 4: first level of the peak search.
  logic [LANES-1:0][63:0] s4_m;
  logic [LANES-1:0]       s4_neg;
  logic [63:0]            s4_mx01, s4_mx23;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_m    <= s3_m;
      s4_neg  <= s3_neg;
      s4_mx01 <= (s3_m[0] > s3_m[1]) ? s3_m[0] : s3_m[1];
      s4_mx23 <= (s3_m[2] > s3_m[3]) ? s3_m[2] : s3_m[3];
    end
  end

  // Stage 5: peak, limit decision and divisor normalization.
  logic [63:0]            peak, peak_sh;
  logic [SHW-1:0]         sh;
  logic                   lim;
  logic [LANES-1:0][63:0] s5_m;
  logic [LANES-1:0]       s5_neg;
  logic [SHW-1:0]         s5_sh;
  logic                   s5_lim;
  logic [DIVW-1:0]        s5_dv;

  always_comb begin
    peak = (s4_mx01 > s4_mx23) ? s4_mx01 : s4_mx23;
    lim  = peak > {11'b0, max_rpm, FRAC'(0)};
    sh   = '0;
    for (int i = DIVW; i < 64; i++) begin
      if (peak[i]) sh = SHW'(i - DIVW + 1);
    end
    peak_sh = peak >> sh;
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_m   <= s4_m;
      s5_neg <= s4_neg;
      s5_sh  <= sh;
      s5_lim <= lim;
      s5_dv  <= peak_sh[DIVW-1:0];
    end
  end

  // Stage 6: dividend and the unlimited result.
  logic [LANES-1:0][NUMW-1:0] s6_num;
  logic [DIVW-1:0]            s6_dv;
  owsm_side_t                 s6_side;
  logic [63:0]                m_sh [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) m_sh[l] = s5_m[l] >> s5_sh;
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      for (int l = 0; l < LANES; l++) begin
        s6_num[l]      <= NUMW'(m_sh[l][DIVW-1:0] * NUMW'(max_rpm));
        s6_side.raw[l] <= s5_m[l][FRAC+QW-1:FRAC];
      end
      s6_side.neg <= s5_neg;
      s6_side.lim <= s5_lim;
      s6_dv       <= s5_dv;
    end
  end

  logic [LANES-1:0][QW-1:0] d_quo;
  owsm_side_t               d_side;

  owsm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v6),
    .in_stall  (d_in_stall),
    .num       (s6_num),
    .dvs       (s6_dv),
    .side_in   (s6_side),
    .out_valid (d_out_valid),
    .out_stall (d_out_stall),
    .quo       (d_quo),
    .side_out  (d_side)
  );

  // Output register: pick quotient or plain result, then restore the sign.
  logic [LANES-1:0][QW-1:0] mag;
  logic [LANES-1:0][15:0]   spd;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag[l] = d_side.lim ? d_quo[l] : d_side.raw[l];
      spd[l] = d_side.neg[l] ? 16'(-{1'b0, mag[l]}) : {1'b0, mag[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_o) begin
      out_valid <= d_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      speed_top_right    <= spd[0];
      speed_bottom_right <= spd[1];
      speed_bottom_left  <= spd[2];
      speed_top_left     <= spd[3];
    end
  end

  // Every delivered magnitude stays within max_rpm.
  logic signed [15:0] lim_hi, lim_lo;
  logic               lim_ok, all_zero;

  assign lim_hi = $signed({1'b0, max_rpm});
  assign lim_lo = -lim_hi;
  assign lim_ok = speed_top_right <= lim_hi && speed_top_right >= lim_lo &&
                  speed_bottom_right <= lim_hi && speed_bottom_right >= lim_lo &&
                  speed_bottom_left <= lim_hi && speed_bottom_left >= lim_lo &&
                  speed_top_left <= lim_hi && speed_top_left >= lim_lo;
  assign all_zero = speed_top_right == 16'sd0 && speed_bottom_right == 16'sd0 &&
                    speed_bottom_left == 16'sd0 && speed_top_left == 16'sd0;

  `OWSM_ASSERT_IMP(a_within_max, out_valid, lim_ok, "wheel speed exceeds max_rpm")
  `OWSM_ASSERT_IMP(a_zero_max, out_valid && max_rpm == 15'd0, all_zero, "nonzero speed at zero max_rpm")
  `OWSM_ASSERT_NXT(a_fill, in_valid && !in_stall, v1, "accepted request lost")

endmodule

>>> hdl/owsm_div.sv
// Pipelined restoring divider, four lanes sharing one divisor, one
// quotient bit per stage. Depends on owsm_pkg and the assertion header.
`include "omni_wheel_speed_mixer_assert.svh"

module owsm_div
  import owsm_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [LANES-1:0][NUMW-1:0]   num,
  input  logic [DIVW-1:0]              dvs,
  input  owsm_side_t                   side_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [LANES-1:0][QW-1:0]     quo,
  output owsm_side_t                   side_out
);

  logic [QW-1:0]                      v;
  logic [QW:0]                        en;
  logic [LANES-1:0][NUMW-1:0]         rem [QW];
  logic [LANES-1:0][QW-1:0]           q   [QW];
  logic [DIVW-1:0]                    dv  [QW];
  owsm_side_t                         sd  [QW];

  assign en[QW] = !out_stall;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;
    logic                          v_prev;
    logic [LANES-1:0][NUMW-1:0]    rem_prev;
    logic [LANES-1:0][QW-1:0]      q_prev;
    logic [DIVW-1:0]               dv_prev;
    owsm_side_t                    sd_prev;
    logic [LANES-1:0][NUMW-1:0]    rem_next;
    logic [LANES-1:0][QW-1:0]      q_next;
    logic [NUMW-1:0]               dsh;

    if (j == 0) begin : g_first
      assign v_prev   = in_valid;
      assign rem_prev = num;
      assign q_prev   = '0;
      assign dv_prev  = dvs;
      assign sd_prev  = side_in;
    end else begin : g_rest
      assign v_prev   = v[j-1];
      assign rem_prev = rem[j-1];
      assign q_prev   = q[j-1];
      assign dv_prev  = dv[j-1];
      assign sd_prev  = sd[j-1];
    end

    assign en[j] = !v[j] || en[j+1];
    assign dsh   = NUMW'(dv_prev) << K;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (rem_prev[l] >= dsh) begin
          rem_next[l] = rem_prev[l] - dsh;
          q_next[l]   = {q_prev[l][QW-2:0], 1'b1};
        end else begin
          rem_next[l] = rem_prev[l];
          q_next[l]   = {q_prev[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en[j]) begin
        v[j] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem[j] <= rem_next;
        q[j]   <= q_next;
        dv[j]  <= dv_prev;
        sd[j]  <= sd_prev;
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[QW-1];
  assign quo       = q[QW-1];
  assign side_out  = sd[QW-1];

  // When limiting, the final remainder must be below the divisor.
  logic rem_ok;
  always_comb begin
    rem_ok = 1'b1;
    for (int l = 0; l < LANES; l++) begin
      if (rem[QW-1][l] >= NUMW'(dv[QW-1])) rem_ok = 1'b0;
    end
  end

  `OWSM_ASSERT_IMP(a_rem_below_dvs, out_valid && side_out.lim, rem_ok, "remainder not reduced")
  `OWSM_ASSERT_NXT(a_fill, in_valid && !in_stall, v[0], "accepted request lost")
  `OWSM_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(quo), "stalled result lost")

endmodule

>>> test/tb_omni_wheel_speed_mixer.sv
// Self-checking testbench for the omni wheel speed mixer: a scoreboard class
// predicts the four wheel speeds of each accepted request. Depends on owsm_pkg.
`timescale 1ns / 100ps

module tb_omni_wheel_speed_mixer
  import owsm_pkg::*;
;

  typedef logic [LANES-1:0][15:0] wheel_speeds_t;

  class wheel_scoreboard;
    logic [47:0] coeffs [LANES];
    logic [31:0] scale;
    logic [14:0] max_rpm;
    wheel_speeds_t pending [$];
    int errors;

    function new();
      for (int i = 0; i < LANES; i++) coeffs[i] = '0;
      scale = SCALE_RESET;
      max_rpm = MAX_RPM_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] data);
      case (idx)
        REG_COEFF_TR, REG_COEFF_BR, REG_COEFF_BL, REG_COEFF_TL: coeffs[idx[1:0]] = data;
        REG_SCALE: scale = data[31:0];
        REG_MAX_RPM: max_rpm = data[14:0];
        default: ;
      endcase
    endfunction

    // Computes the wheel speeds for one move command and queues them.
    function void note_request(logic signed [15:0] fwd, logic signed [15:0] lft,
                               logic signed [15:0] rot);
      longint sum;
      logic [63:0] a, peak, limit, dv;
      logic [63:0] mag [LANES];
      logic neg [LANES];
      wheel_speeds_t res;
      int s;
      peak = '0;
      for (int i = 0; i < LANES; i++) begin
        sum = longint'(fwd) * longint'($signed(coeffs[i][15:0]))
            + longint'(lft) * longint'($signed(coeffs[i][31:16]))
            + longint'(rot) * longint'($signed(coeffs[i][47:32]));
        neg[i] = sum < 0;
        a = neg[i] ? 64'(-sum) : 64'(sum);
        mag[i] = a * 64'(scale);
        if (mag[i] > peak) peak = mag[i];
      end
      limit = 64'(max_rpm) << FRAC;
      if (peak > limit) begin
        s = 0;
        while ((peak >> s) >= (64'd1 << DIVW)) s++;
        dv = peak >> s;
        for (int i = 0; i < LANES; i++) mag[i] = ((mag[i] >> s) * 64'(max_rpm)) / dv;
      end else begin
        for (int i = 0; i < LANES; i++) mag[i] = mag[i] >> FRAC;
      end
      for (int i = 0; i < LANES; i++) begin
        a = neg[i] ? -mag[i] : mag[i];
        res[i] = a[15:0];
      end
      pending.push_back(res);
    endfunction

    function void check_result(wheel_speeds_t got);
      wheel_speeds_t want;
      bit bad;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      bad = 0;
      for (int i = 0; i < LANES; i++) if (want[i] !== got[i]) bad = 1;
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected tr %0d br %0d bl %0d tl %0d, got tr %0d br %0d bl %0d tl %0d",
                   $signed(want[0]), $signed(want[1]), $signed(want[2]), $signed(want[3]),
                   $signed(got[0]), $signed(got[1]), $signed(got[2]), $signed(got[3]));
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_write = 0;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid;
  logic signed [15:0] forward_speed = '0, left_speed = '0, turn_rate = '0;
  logic signed [15:0] speed_top_right, speed_bottom_right, speed_bottom_left, speed_top_left;

  wheel_scoreboard board = new();
  int stall_pct = 0;
  bit hold_off = 0;

  omni_wheel_speed_mixer DUT (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      board.check_result({speed_top_left, speed_bottom_left, speed_bottom_right,
                          speed_top_right});

  // Receiver: random stalls at a rate set per phase, plus one long hold-off.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1;
        for (n = 0; n < 300; n++) @(negedge clk);
        hold_off = 0;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] data);
    @(negedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_write <= 0;
  endtask

  // Offers one request and returns once it has been accepted, leaving valid high.
  task automatic send_cmd(logic [15:0] f, logic [15:0] l, logic [15:0] r);
    @(negedge clk);
    in_valid <= 1;
    forward_speed <= f;
    left_speed <= l;
    turn_rate <= r;
    do @(posedge clk); while (in_stall);
    board.note_request(f, l, r);
  endtask

  task automatic idle(int cycles);
    @(negedge clk);
    in_valid <= 0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    idle(0);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_coeffs();
    logic [47:0] c;
    c = {$urandom, $urandom};
    if ($urandom_range(3) != 0)
      c = {16'($signed($urandom_range(8192)) - 4096),
           16'($signed($urandom_range(32768)) - 16384),
           16'($signed($urandom_range(32768)) - 16384)};
    return c;
  endfunction

  function automatic logic [15:0] rand_speed();
    if ($urandom_range(3) == 0) return 16'($signed($urandom_range(1024)) - 512);
    return 16'($urandom);
  endfunction

  task automatic random_config();
    for (int i = 0; i < LANES; i++) write_reg(3'(i), rand_coeffs());
    case ($urandom_range(3))
      0: write_reg(REG_SCALE, 48'($urandom));
      1: write_reg(REG_SCALE, 48'($urandom_range(32'h000f_ffff)));
      2: write_reg(REG_SCALE, 48'($urandom_range(32'h0000_ffff)));
      default: write_reg(REG_SCALE, 48'hffff_ffff);
    endcase
    case ($urandom_range(3))
      0: write_reg(REG_MAX_RPM, 48'd1);
      1: write_reg(REG_MAX_RPM, 48'd32767);
      default: write_reg(REG_MAX_RPM, 48'($urandom_range(32767, 1)));
    endcase
  endtask

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [15:0] ext [4];
    ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Reset coefficients are zero: every wheel speed must be zero.
    send_cmd(16'h7fff, 16'h8000, 16'h1234);
    drain();

    // Realistic wheel geometry, unit scale, default limit.
    write_reg(REG_COEFF_TR, {16'h1000, 16'h2d41, 16'hd2bf});
    write_reg(REG_COEFF_BR, {16'h1000, 16'hd2bf, 16'hd2bf});
    write_reg(REG_COEFF_BL, {16'h1000, 16'hd2bf, 16'h2d41});
    write_reg(REG_COEFF_TL, {16'h1000, 16'h2d41, 16'h2d41});
    for (int i = 0; i < 4; i++) send_cmd(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]);
    send_cmd(16'h0100, 16'h0000, 16'h0000);
    send_cmd(16'h0000, 16'h0100, 16'h0000);
    send_cmd(16'h0000, 16'h0000, 16'h0100);
    drain();

    // Extreme coefficients and scale force limiting and the widest products.
    for (int i = 0; i < LANES; i++) write_reg(3'(i), {16'h8000, 16'h8000, 16'h8000});
    write_reg(REG_COEFF_TL, {16'h7fff, 16'h7fff, 16'h7fff});
    write_reg(REG_SCALE, 48'hffff_ffff);
    write_reg(REG_MAX_RPM, 48'd32767);
    for (int i = 0; i < 4; i++) send_cmd(ext[i], ext[i], ext[i]);
    drain();
    write_reg(REG_MAX_RPM, 48'd1);
    send_cmd(16'h8000, 16'h8000, 16'h8000);
    send_cmd(16'h0001, 16'hffff, 16'h0001);
    drain();
    // A zero limit drives every wheel to zero; a zero scale does the same.
    write_reg(REG_MAX_RPM, 48'd0);
    send_cmd(16'h4000, 16'hc000, 16'h0100);
    drain();
    write_reg(REG_SCALE, 48'd0);
    write_reg(REG_MAX_RPM, 48'd32767);
    send_cmd(16'h4000, 16'hc000, 16'h0100);
    drain();
    // An unknown register index must not disturb anything.
    write_reg(3'd6, 48'hffff_ffff_ffff);
    write_reg(3'd7, 48'h0);
    write_reg(REG_SCALE, 48'h0001_0000);
    send_cmd(16'h0200, 16'h0300, 16'hff00);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      random_config();
      stall_pct = (phase % 4 == 0) ? 0 : $urandom_range(70);
      if (phase == 5) hold_off = 1;
      for (int n = 0; n < 100; ) begin
        int burst;
        burst = $urandom_range(20, 1);
        for (int k = 0; k < burst && n < 100; k++, n++)
          send_cmd(rand_speed(), rand_speed(), rand_speed());
        if ($urandom_range(2) == 0) idle($urandom_range(8));
      end
      drain();
    end

    if (board.pending.size() != 0) board.errors++;
    if (board.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
